// ----- hw/rtl/grid_raycast_column_top_macros.svh -----
// Assertion macros shared by the grid ray-cast column block.
// Uses the clock and reset names of the including module.
`ifndef GRID_RAYCAST_COLUMN_TOP_MACROS_SVH
`define GRID_RAYCAST_COLUMN_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GRC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define GRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/grc_pkg.sv -----
// Package of the grid ray-cast column block: sizes, codes, types.
// No dependencies; every other file but the macros header imports it.
`default_nettype none
package grc_pkg;

   localparam int SCREEN_ROWS    = 40;
   localparam int SCREEN_COLUMNS = 120;
   localparam int MAP_SIZE       = 16;

   localparam int POS_W   = 16;
   localparam int ANG_W   = 12;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 6;
   localparam int GLYPH_W = 4;
   localparam int DIST_W  = 16;
   localparam int LINE_W  = 10;
   localparam int SIN_W   = 17;
   localparam int ACC_W   = 34;
   localparam int D_W     = 18;
   localparam int DMAX_W  = 17;
   localparam int CELL_W  = 4;
   localparam int MAPV_W  = 256;
   localparam int FOV_W   = 12;
   localparam int DEPTH_W = 5;
   localparam int STEP_W  = 12;
   localparam int CSR_W   = 64;
   localparam int ADDR_W  = 6;
   localparam int NUM_W   = 17 + $clog2(SCREEN_ROWS + 1);

   // Reciprocal for the division of column * fov by the screen width.
   localparam int RECIP_SHIFT = 32;
   localparam longint unsigned RECIP_L =
      ((64'd1 << RECIP_SHIFT) + SCREEN_COLUMNS - 1) / SCREEN_COLUMNS;
   localparam logic [31:0] RECIP = RECIP_L[31:0];

   localparam logic [FOV_W-1:0]   FOV_RESET   = 12'd512;
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd16;
   localparam logic [STEP_W-1:0]  STEP_RESET  = 12'd410;

   typedef enum logic [2:0] {
      REG_MAP0  = 3'd0,
      REG_MAP1  = 3'd1,
      REG_MAP2  = 3'd2,
      REG_MAP3  = 3'd3,
      REG_FOV   = 3'd4,
      REG_DEPTH = 3'd5,
      REG_STEP  = 3'd6
   } grc_reg_type;

   typedef enum logic [GLYPH_W-1:0] {
      GLYPH_BLANK  = 4'd0,
      GLYPH_FULL   = 4'd1,
      GLYPH_DARK   = 4'd2,
      GLYPH_MEDIUM = 4'd3,
      GLYPH_LIGHT  = 4'd4,
      GLYPH_HASH   = 4'd5,
      GLYPH_X      = 4'd6,
      GLYPH_DOT    = 4'd7,
      GLYPH_DASH   = 4'd8
   } grc_glyph_type;

   typedef struct packed {
      logic [MAPV_W-1:0] map;
      logic [FOV_W-1:0]  fov;
      logic [DEPTH_W-1:0] depth;
      logic [STEP_W-1:0] step;
   } grc_cfg_type;

   typedef struct packed {
      logic [POS_W-1:0]        px;
      logic [POS_W-1:0]        py;
      logic signed [SIN_W-1:0] ex;
      logic signed [SIN_W-1:0] ey;
   } grc_ray_type;

   typedef struct packed {
      logic push;
      logic full;
   } grc_qctl_type;

   typedef enum logic [2:0] {
      F_IDLE, F_MUL, F_RECIP, F_SQUARE, F_POLY1, F_POLY2, F_POLY3, F_PUSH
   } grc_front_state_type;

   typedef enum logic [3:0] {
      B_IDLE, B_INIT, B_MARCH, B_CSEL, B_CMUL, B_CSUM, B_CSQD, B_CSQC,
      B_CSCALE, B_CTEST, B_DIVSET, B_DIV, B_SHADE, B_EMIT
   } grc_back_state_type;

endpackage
`default_nettype wire

// ----- hw/rtl/grc_if.sv -----
// Valid/ready channel interfaces of the grid ray-cast column block.
// Depends on grc_pkg for field widths.
`default_nettype none
interface grc_req_if import grc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] player_x;
   logic [POS_W-1:0] player_y;
   logic [ANG_W-1:0] player_angle;
   logic [COL_W-1:0] column;
   modport source (output valid, player_x, player_y, player_angle, column, input ready);
   modport sink (input valid, player_x, player_y, player_angle, column, output ready);
endinterface

interface grc_rsp_if import grc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [ROW_W-1:0]         row;
   logic [GLYPH_W-1:0]       glyph;
   logic [DIST_W-1:0]        wall_distance;
   logic signed [LINE_W-1:0] ceiling_row;
   logic [LINE_W-1:0]        floor_row;
   logic                     edge_flag;
   logic                     last;
   modport source (output valid, row, glyph, wall_distance, ceiling_row, floor_row,
                   edge_flag, last, input ready);
   modport sink (input valid, row, glyph, wall_distance, ceiling_row, floor_row,
                 edge_flag, last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/grc_front.sv -----
// Front end: accepts a transaction, forms the ray angle and its sine/cosine.
// Depends on grc_pkg and grc_req_if.
`default_nettype none
module grc_front import grc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   grc_req_if.sink          req_chan,
   input  wire logic [FOV_W-1:0] fov,
   output grc_qctl_type     qctl,
   input  wire logic        q_full,
   output grc_ray_type      ray_out
);
   grc_front_state_type state_ff, state_in;
   logic [POS_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [ANG_W-1:0] pa_ff, pa_in, ray_ff, ray_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [18:0] prod_ff, prod_in;
   logic phase_ff, phase_in, neg_ff, neg_in;
   logic [14:0] x_ff, x_in, x2_ff, x2_in;
   logic [14:0] t_ff, t_in;
   logic signed [SIN_W-1:0] ex_ff, ex_in, ey_ff, ey_in;

   logic [50:0] recip_prod;
   logic [ANG_W-1:0] ang;
   logic [10:0] arg;
   logic [14:0] x_c;
   logic [29:0] sq;
   logic [28:0] p1;
   logic [28:0] p2;
   logic [29:0] p3;
   logic [15:0] mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      px_ff <= px_in; py_ff <= py_in; pa_ff <= pa_in; col_ff <= col_in;
      prod_ff <= prod_in; ray_ff <= ray_in; phase_ff <= phase_in; neg_ff <= neg_in;
      x_ff <= x_in; x2_ff <= x2_in; t_ff <= t_in; ex_ff <= ex_in; ey_ff <= ey_in;
   end

   always_comb begin
      state_in = state_ff;
      px_in = px_ff; py_in = py_ff; pa_in = pa_ff; col_in = col_ff;
      prod_in = prod_ff; ray_in = ray_ff; phase_in = phase_ff; neg_in = neg_ff;
      x_in = x_ff; x2_in = x2_ff; t_in = t_ff; ex_in = ex_ff; ey_in = ey_ff;
      req_chan.ready = (state_ff == F_IDLE);
      qctl.push = 1'b0;
      qctl.full = q_full;

      recip_prod = 51'(prod_ff) * 51'(RECIP);
      ang = phase_ff ? (ray_ff + 12'd1024) : ray_ff;
      arg = ang[10] ? (11'd1024 - {1'b0, ang[9:0]}) : {1'b0, ang[9:0]};
      x_c = {arg, 4'b0};
      sq = 30'(x_c) * 30'(x_c);
      p1 = 29'(x2_ff) * 29'd1160;
      p2 = 29'(14'd10512 - t_ff[13:0]) * 29'(x2_ff);
      p3 = 30'(15'd25736 - t_ff) * 30'(x_ff);
      mag = p3[29:14];

      case (state_ff)
         F_IDLE: begin
            if (req_chan.valid) begin
               px_in = req_chan.player_x;
               py_in = req_chan.player_y;
               pa_in = req_chan.player_angle;
               col_in = req_chan.column;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            prod_in = 19'(col_ff) * 19'(fov);
            state_in = F_RECIP;
         end
         F_RECIP: begin
            ray_in = pa_ff - {1'b0, fov[FOV_W-1:1]} + recip_prod[RECIP_SHIFT +: ANG_W];
            phase_in = 1'b0;
            state_in = F_SQUARE;
         end
         F_SQUARE: begin
            x_in = x_c;
            neg_in = ang[11];
            x2_in = sq[28:14];
            state_in = F_POLY1;
         end
         F_POLY1: begin
            t_in = 15'(p1[28:14]);
            state_in = F_POLY2;
         end
         F_POLY2: begin
            t_in = p2[28:14];
            state_in = F_POLY3;
         end
         F_POLY3: begin
            if (phase_ff) begin
               ey_in = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
               state_in = F_PUSH;
            end else begin
               ex_in = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
               phase_in = 1'b1;
               state_in = F_SQUARE;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               qctl.push = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign ray_out.px = px_ff;
   assign ray_out.py = py_ff;
   assign ray_out.ex = ex_ff;
   assign ray_out.ey = ey_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/grc_queue.sv -----
// Two-entry queue of ray descriptors between the front and back ends.
// Depends on grc_pkg.
`default_nettype none
module grc_queue import grc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire grc_qctl_type qctl,
   input  wire grc_ray_type push_data,
   output logic        full,
   input  wire logic   pop,
   output grc_ray_type pop_data,
   output logic        empty
);
   grc_ray_type slot_ff [2];
   logic wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
      if (qctl.push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_comb begin
      wr_in = qctl.push ? ~wr_ff : wr_ff;
      rd_in = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, qctl.push} - {1'b0, pop};
      full = (cnt_ff == 2'd2);
      empty = (cnt_ff == 2'd0);
      pop_data = slot_ff[rd_ff];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/grc_back.sv -----
// Back end: marches the ray, tests corners, divides for the rows, emits rows.
// Depends on grc_pkg and grc_rsp_if.
`default_nettype none
module grc_back import grc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire grc_cfg_type cfg,
   input  wire logic  q_empty,
   input  wire grc_ray_type ray_in,
   output logic       q_pop,
   grc_rsp_if.source  rsp_chan
);
   localparam logic [11:0] H12 = 12'(SCREEN_ROWS);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);

   grc_back_state_type state_ff, state_in;
   grc_ray_type r_ff, r_in;
   logic [D_W-1:0] d_ff, d_in;
   logic signed [ACC_W-1:0] ax_ff, ax_in, ay_ff, ay_in, ix_ff, ix_in, iy_ff, iy_in;
   logic [CELL_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [17:0] vx0_ff, vx0_in, vx1_ff, vx1_in, vy0_ff, vy0_in, vy1_ff, vy1_in;
   logic [1:0] excl_ff, excl_in, cidx_ff, cidx_in;
   logic signed [34:0] pa_ff, pa_in, pb_ff, pb_in;
   logic signed [33:0] dot_ff, dot_in;
   logic [32:0] cr_ff, cr_in;
   logic dpos_ff, dpos_in, edge_ff, edge_in;
   logic [65:0] sqd_ff, sqd_in, sqc_ff, sqc_in;
   logic [79:0] lhs_ff, lhs_in;
   logic neg_ff, neg_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [D_W:0] rem_ff, rem_in;
   logic [$clog2(NUM_W+1)-1:0] cnt_ff, cnt_in;
   logic signed [LINE_W-1:0] c_ff, c_in;
   logic [LINE_W-1:0] f_ff, f_in;
   logic [GLYPH_W-1:0] gw_ff, gw_in;
   logic [DIST_W-1:0] wd_ff, wd_in;
   logic [ROW_W-1:0] y_ff, y_in;
   logic ov_ff, ov_in;
   logic [ROW_W-1:0] orow_ff, orow_in;
   logic [GLYPH_W-1:0] oglyph_ff, oglyph_in;
   logic olast_ff, olast_in;

   logic [DEPTH_W-1:0] dep;
   logic [STEP_W-1:0] st;
   logic [DMAX_W-1:0] dmax;
   logic [D_W-1:0] d_n;
   logic signed [ACC_W-1:0] ax_n, ay_n;
   logic out_map;
   logic signed [17:0] vx0_c, vx1_c, vy0_c, vy1_c, avx0, avx1, avy0, avy1, vx, vy;
   logic signed [33:0] crs;
   logic [D_W:0] dvs, rem_sh;
   logic [16:0] mag;
   logic [NUM_W-1:0] q;
   logic signed [LINE_W-1:0] c_c;
   logic [D_W+2:0] d4, d3, d2;
   logic [8:0] b2;
   logic [GLYPH_W-1:0] g;
   logic load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
      end
      r_ff <= r_in; d_ff <= d_in; ax_ff <= ax_in; ay_ff <= ay_in; ix_ff <= ix_in;
      iy_ff <= iy_in; cx_ff <= cx_in; cy_ff <= cy_in; vx0_ff <= vx0_in; vx1_ff <= vx1_in;
      vy0_ff <= vy0_in; vy1_ff <= vy1_in; excl_ff <= excl_in; cidx_ff <= cidx_in;
      pa_ff <= pa_in; pb_ff <= pb_in; dot_ff <= dot_in; cr_ff <= cr_in;
      dpos_ff <= dpos_in; edge_ff <= edge_in; sqd_ff <= sqd_in; sqc_ff <= sqc_in;
      lhs_ff <= lhs_in; neg_ff <= neg_in; num_ff <= num_in; rem_ff <= rem_in;
      cnt_ff <= cnt_in; c_ff <= c_in; f_ff <= f_in; gw_ff <= gw_in; wd_ff <= wd_in;
      y_ff <= y_in; orow_ff <= orow_in; oglyph_ff <= oglyph_in; olast_ff <= olast_in;
   end

   always_comb begin
      state_in = state_ff;
      r_in = r_ff; d_in = d_ff; ax_in = ax_ff; ay_in = ay_ff; ix_in = ix_ff; iy_in = iy_ff;
      cx_in = cx_ff; cy_in = cy_ff; vx0_in = vx0_ff; vx1_in = vx1_ff; vy0_in = vy0_ff;
      vy1_in = vy1_ff; excl_in = excl_ff; cidx_in = cidx_ff; pa_in = pa_ff; pb_in = pb_ff;
      dot_in = dot_ff; cr_in = cr_ff; dpos_in = dpos_ff; edge_in = edge_ff;
      sqd_in = sqd_ff; sqc_in = sqc_ff; lhs_in = lhs_ff; neg_in = neg_ff;
      num_in = num_ff; rem_in = rem_ff; cnt_in = cnt_ff; c_in = c_ff; f_in = f_ff;
      gw_in = gw_ff; wd_in = wd_ff; y_in = y_ff;
      orow_in = orow_ff; oglyph_in = oglyph_ff; olast_in = olast_ff;
      q_pop = 1'b0;
      load = 1'b0;

      dep = (cfg.depth == '0) ? DEPTH_W'(1) : cfg.depth;
      st = (cfg.step == '0) ? STEP_W'(1) : cfg.step;
      dmax = {dep, 12'b0};

      // one march step
      d_n = d_ff + D_W'(st);
      ax_n = ax_ff + ix_ff;
      ay_n = ay_ff + iy_ff;
      out_map = ax_n[ACC_W-1] || ay_n[ACC_W-1] ||
                (ax_n[ACC_W-2:26] >= 7'(MAP_SIZE)) || (ay_n[ACC_W-2:26] >= 7'(MAP_SIZE));

      // corner offsets from the player
      vx0_c = $signed({1'b0, 17'({cx_ff, 12'b0})}) - $signed({2'b0, r_ff.px});
      vx1_c = $signed({1'b0, 17'({cx_ff, 12'b0}) + 17'd4096}) - $signed({2'b0, r_ff.px});
      vy0_c = $signed({1'b0, 17'({cy_ff, 12'b0})}) - $signed({2'b0, r_ff.py});
      vy1_c = $signed({1'b0, 17'({cy_ff, 12'b0}) + 17'd4096}) - $signed({2'b0, r_ff.py});
      avx0 = vx0_c[17] ? -vx0_c : vx0_c;
      avx1 = vx1_c[17] ? -vx1_c : vx1_c;
      avy0 = vy0_c[17] ? -vy0_c : vy0_c;
      avy1 = vy1_c[17] ? -vy1_c : vy1_c;
      vx = cidx_ff[1] ? vx1_ff : vx0_ff;
      vy = cidx_ff[0] ? vy1_ff : vy0_ff;
      crs = 34'(pa_ff - pb_ff);

      // divider setup and step
      mag = (d_ff < D_W'(8192)) ? 17'(D_W'(8192) - d_ff) : 17'(d_ff - D_W'(8192));
      dvs = {d_ff, 1'b0};
      rem_sh = {rem_ff[D_W-1:0], num_ff[NUM_W-1]};
      q = num_ff;
      if (neg_ff) begin
         c_c = (q > NUM_W'(512)) ? -LINE_W'(512) : -$signed(LINE_W'(q));
      end else begin
         c_c = $signed(LINE_W'(q));
      end

      d4 = {d_ff, 2'b0};
      d2 = {1'b0, d_ff, 1'b0};
      d3 = d2 + (D_W+3)'(d_ff);

      // row glyph
      b2 = 9'(2 * SCREEN_ROWS) - {2'b0, y_ff, 1'b0};
      if ($signed({4'b0, y_ff}) <= c_ff) begin
         g = GLYPH_BLANK;
      end else if ({4'b0, y_ff} <= f_ff) begin
         g = gw_ff;
      end else if ({1'b0, b2, 2'b0} < H12) begin
         g = GLYPH_HASH;
      end else if ({2'b0, b2, 1'b0} < H12) begin
         g = GLYPH_X;
      end else if ({1'b0, b2, 2'b0} < 12'(3 * SCREEN_ROWS)) begin
         g = GLYPH_DOT;
      end else if (12'(b2) * 12'd10 < 12'(9 * SCREEN_ROWS)) begin
         g = GLYPH_DASH;
      end else begin
         g = GLYPH_BLANK;
      end

      case (state_ff)
         B_IDLE: begin
            // hold the next ray until the final row of this column has left
            if (!q_empty && (!ov_ff || rsp_chan.ready)) begin
               q_pop = 1'b1;
               r_in = ray_in;
               d_in = '0;
               edge_in = 1'b0;
               state_in = B_INIT;
            end
         end
         B_INIT: begin
            ix_in = ACC_W'(r_ff.ex * $signed({1'b0, st}));
            iy_in = ACC_W'(r_ff.ey * $signed({1'b0, st}));
            ax_in = $signed(ACC_W'({r_ff.px, 14'b0}));
            ay_in = $signed(ACC_W'({r_ff.py, 14'b0}));
            state_in = B_MARCH;
         end
         B_MARCH: begin
            d_in = d_n;
            ax_in = ax_n;
            ay_in = ay_n;
            cx_in = ax_n[26 +: CELL_W];
            cy_in = ay_n[26 +: CELL_W];
            if (out_map) begin
               d_in = D_W'(dmax);
               state_in = B_DIVSET;
            end else if (cfg.map[{ay_n[26 +: CELL_W], ax_n[26 +: CELL_W]}]) begin
               state_in = B_CSEL;
            end else if (d_n >= D_W'(dmax)) begin
               state_in = B_DIVSET;
            end
         end
         B_CSEL: begin
            vx0_in = vx0_c; vx1_in = vx1_c; vy0_in = vy0_c; vy1_in = vy1_c;
            // the farthest corner, later index on ties, is skipped
            excl_in = {avx1 >= avx0, avy1 >= avy0};
            cidx_in = 2'd0;
            state_in = B_CMUL;
         end
         B_CMUL: begin
            if (cidx_ff == excl_ff) begin
               if (cidx_ff == 2'd3) begin
                  state_in = B_DIVSET;
               end else begin
                  cidx_in = cidx_ff + 2'd1;
               end
            end else begin
               pa_in = 35'(r_ff.ex * vx);
               pb_in = 35'(r_ff.ey * vy);
               state_in = B_CSUM;
            end
         end
         B_CSUM: begin
            dot_in = 34'(pa_ff + pb_ff);
            pa_in = 35'(r_ff.ex * vy);
            pb_in = 35'(r_ff.ey * vx);
            state_in = B_CSQD;
         end
         B_CSQD: begin
            cr_in = 33'(crs[33] ? -crs : crs);
            dpos_in = !dot_ff[33] && (dot_ff != '0);
            sqd_in = 66'(33'(dot_ff[33] ? -dot_ff : dot_ff)) *
                     66'(33'(dot_ff[33] ? -dot_ff : dot_ff));
            state_in = B_CSQC;
         end
         B_CSQC: begin
            sqc_in = 66'(cr_ff) * 66'(cr_ff);
            state_in = B_CSCALE;
         end
         B_CSCALE: begin
            // c^2 < floor(dot^2/9999) is the same as 9999*(c^2+1) <= dot^2
            lhs_in = (80'(sqc_ff) + 80'd1) * 80'd9999;
            state_in = B_CTEST;
         end
         B_CTEST: begin
            if (dpos_ff && (lhs_ff <= 80'(sqd_ff))) begin
               edge_in = 1'b1;
            end
            if (cidx_ff == 2'd3) begin
               state_in = B_DIVSET;
            end else begin
               cidx_in = cidx_ff + 2'd1;
               state_in = B_CMUL;
            end
         end
         B_DIVSET: begin
            neg_in = d_ff < D_W'(8192);
            num_in = NUM_W'(mag) * NUM_W'(SCREEN_ROWS);
            rem_in = '0;
            cnt_in = '0;
            state_in = B_DIV;
         end
         B_DIV: begin
            if (rem_sh >= dvs) begin
               rem_in = rem_sh - dvs;
               num_in = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               num_in = {num_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ($bits(cnt_ff))'(NUM_W - 1)) begin
               state_in = B_SHADE;
            end
         end
         B_SHADE: begin
            c_in = c_c;
            f_in = LINE_W'(SCREEN_ROWS) - LINE_W'(c_c);
            if (edge_ff) begin
               gw_in = GLYPH_BLANK;
            end else if (d4 <= (D_W+3)'(dmax)) begin
               gw_in = GLYPH_FULL;
            end else if (d3 <= (D_W+3)'(dmax)) begin
               gw_in = GLYPH_DARK;
            end else if (d2 <= (D_W+3)'(dmax)) begin
               gw_in = GLYPH_MEDIUM;
            end else if (d_ff <= D_W'(dmax)) begin
               gw_in = GLYPH_LIGHT;
            end else begin
               gw_in = GLYPH_BLANK;
            end
            if ((d_ff >= D_W'(dmax) ? D_W'(dmax) : d_ff) > D_W'(16'hFFFF)) begin
               wd_in = 16'hFFFF;
            end else begin
               wd_in = (d_ff >= D_W'(dmax)) ? DIST_W'(dmax) : DIST_W'(d_ff);
            end
            y_in = '0;
            state_in = B_EMIT;
         end
         B_EMIT: begin
            if (!ov_ff || rsp_chan.ready) begin
               load = 1'b1;
               orow_in = y_ff;
               oglyph_in = g;
               olast_in = (y_ff == LAST_ROW);
               if (y_ff == LAST_ROW) begin
                  state_in = B_IDLE;
               end else begin
                  y_in = y_ff + 1'b1;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase

      ov_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : ov_ff);
   end

   assign rsp_chan.valid = ov_ff;
   assign rsp_chan.row = orow_ff;
   assign rsp_chan.glyph = oglyph_ff;
   assign rsp_chan.wall_distance = wd_ff;
   assign rsp_chan.ceiling_row = c_ff;
   assign rsp_chan.floor_row = f_ff;
   assign rsp_chan.edge_flag = edge_ff;
   assign rsp_chan.last = olast_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/grid_raycast_column_top.sv -----
// Top level of the grid ray-cast column block: registers, front, queue, back.
// Depends on grc_pkg, grc_if, grc_front, grc_queue, grc_back and the macros header.
//
// Usage: req_chan carries one transaction per screen column (player x/y in
// Q4.12 cells, view angle, column). rsp_chan returns SCREEN_ROWS transactions
// for it, rows 0 up, with last set on the final row. Map, field of view, depth
// and step are written over the APB port; the user must write them only while
// the block is idle, which the block itself does not enforce.
// Operation: the front end forms the ray and its sine/cosine; the back end
// then marches one step per cycle (up to depth*4096/step steps, 160 at reset
// values), tests the corners on a wall hit, divides for the ceiling row and
// then emits one row per cycle while rsp_chan takes them.
// Throughput: the back end (march, corners, divider, rows) sets the rate; the front
// end prepares the next ray meanwhile through a two-entry queue.
// Reset: synchronous, clears control state and loads register defaults.
// Stalls: a stalled rsp_chan holds the row in the output register and
// pauses the back end, which takes no new ray until the final row has left;
// the front end keeps taking transactions until the queue fills.
`default_nettype none
`include "grid_raycast_column_top_macros.svh"
module grid_raycast_column_top import grc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   grc_req_if.sink                req_chan,
   grc_rsp_if.source              rsp_chan,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [CSR_W-1:0]  pwdata,
   output logic [CSR_W-1:0]       prdata,
   output logic                   pready
);
   logic [CSR_W-1:0] map_ff [4];
   logic [CSR_W-1:0] map_in [4];
   logic [FOV_W-1:0] fov_ff, fov_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic wr;
   grc_reg_type idx;
   grc_cfg_type cfg;
   grc_qctl_type qctl;
   grc_ray_type q_push_data, q_pop_data;
   logic q_full, q_empty, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            map_ff[i] <= '0;
         end
         fov_ff <= FOV_RESET;
         depth_ff <= DEPTH_RESET;
         step_ff <= STEP_RESET;
      end else begin
         map_ff <= map_in;
         fov_ff <= fov_in;
         depth_ff <= depth_in;
         step_ff <= step_in;
      end
   end

   // Decode one write per APB access phase; unknown addresses drop the data.
   always_comb begin
      pready = 1'b1;
      wr = psel && penable && pwrite;
      idx = grc_reg_type'(paddr[5:3]);
      map_in = map_ff;
      fov_in = fov_ff;
      depth_in = depth_ff;
      step_in = step_ff;
      prdata = '0;
      case (idx)
         REG_MAP0: prdata = map_ff[0];
         REG_MAP1: prdata = map_ff[1];
         REG_MAP2: prdata = map_ff[2];
         REG_MAP3: prdata = map_ff[3];
         REG_FOV: prdata = CSR_W'(fov_ff);
         REG_DEPTH: prdata = CSR_W'(depth_ff);
         REG_STEP: prdata = CSR_W'(step_ff);
         default: prdata = '0;
      endcase
      if (wr) begin
         case (idx)
            REG_MAP0: map_in[0] = pwdata;
            REG_MAP1: map_in[1] = pwdata;
            REG_MAP2: map_in[2] = pwdata;
            REG_MAP3: map_in[3] = pwdata;
            REG_FOV: fov_in = pwdata[FOV_W-1:0];
            REG_DEPTH: depth_in = pwdata[DEPTH_W-1:0];
            REG_STEP: step_in = pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
      // map row r sits at bit 16*r of the flat vector
      cfg.map = {map_ff[3], map_ff[2], map_ff[1], map_ff[0]};
      cfg.fov = fov_ff;
      cfg.depth = depth_ff;
      cfg.step = step_ff;
   end

   grc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .fov     (fov_ff),
      .qctl    (qctl),
      .q_full  (q_full),
      .ray_out (q_push_data)
   );

   grc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .qctl     (qctl),
      .push_data(q_push_data),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_pop_data),
      .empty    (q_empty)
   );

   grc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_empty (q_empty),
      .ray_in  (q_pop_data),
      .q_pop   (q_pop),
      .rsp_chan(rsp_chan)
   );

   `GRC_ASSERT_IMP(a_no_push_full, qctl.push, !q_full, "push into full queue")
   `GRC_ASSERT_IMP(a_no_pop_empty, q_pop, !q_empty, "pop from empty queue")
   `GRC_ASSERT_IMP(a_last_row, rsp_chan.valid && rsp_chan.last,
      rsp_chan.row == ROW_W'(SCREEN_ROWS - 1), "last flag off the final row")
   `GRC_ASSERT_NEXT(a_rows_follow, rsp_chan.valid && rsp_chan.ready && !rsp_chan.last,
      rsp_chan.valid && (rsp_chan.row == $past(rsp_chan.row) + 1'b1),
      "row sequence broken")
endmodule
`default_nettype wire
